FILE: rtl/h264fu_pkg.sv
// ----------------------------------------------------------------------------
// h264fu_pkg: shared types and constants of the H.264 FU-A packetizer
// Word layouts of both channels, the configuration register map, the NAL and
// FU-A code points, and the bundle of results made from one input word.
// ----------------------------------------------------------------------------
package h264fu_pkg;

	localparam int unsigned MAX_UNIT_BYTES = 65535;

	localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1400;
	localparam logic [16:0] TS_STEP_RST     = 17'(90000 / 25);

	localparam logic [7:0] NRI_MASK  = 8'h60;
	localparam logic [7:0] TYPE_MASK = 8'h1F;
	localparam logic [7:0] FU_START  = 8'h80;
	localparam logic [7:0] FU_END    = 8'h40;
	localparam logic [4:0] FU_A_TYPE = 5'd28;
	localparam logic [4:0] SPS_TYPE  = 5'd7;
	localparam logic [4:0] PPS_TYPE  = 5'd8;

	typedef enum logic [0:0] {
		CFG_MAX_PAYLOAD = 1'b0,
		CFG_TS_STEP     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [10:0] max_payload;
		logic [16:0] timestamp_step;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  nal_byte;
		logic        unit_first;
		logic [15:0] unit_size;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        packet_first;
		logic        packet_last;
		logic [15:0] sequence_number;
		logic [31:0] rtp_timestamp;
		logic        run_last;
	} out_word_t;

	// Up to three output words come from one input word; they share the
	// sequence number and timestamp.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [2:0]      pkt_first;
		logic [2:0]      pkt_last;
		logic [1:0]      n_res;
		logic [15:0]     seq;
		logic [31:0]     ts;
	} bundle_t;

	typedef struct packed {
		logic [7:0]  held;
		logic        fmode;
		logic [15:0] brem;
		logic [10:0] fill;
		logic        first;
		logic [15:0] seq;
		logic [31:0] ts;
	} state_t;

endpackage

FILE: rtl/h264_rtp_fua_packetizer_unit.sv
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_unit: H.264 RTP packetizer, single NAL and FU-A
// Input register, packetizer state logic and output serializer.
// ----------------------------------------------------------------------------
// The block takes one NAL unit byte per cycle while in_stall is low and
// delivers RTP payload words with packet boundaries, sequence number and
// timestamp. A data byte inside a unit yields one output word; the first byte
// of each FU-A fragment yields three, since the output register must send the
// FU indicator and FU header ahead of it, and the input side stalls while
// those extra words drain. The header byte of a fragmented unit is held and
// delivers no word. An item waits at most in the input register while the
// output register still drains, so accepting and delivering overlap.
// Configuration writes are always ready and take effect on the next cycle.
module h264_rtp_fua_packetizer_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  h264fu_pkg::in_word_t   in_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output h264fu_pkg::out_word_t  out_word,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  h264fu_pkg::cfg_idx_t   cfg_index,
	input  logic [16:0]            cfg_data
);
	import h264fu_pkg::*;

	cfg_t     cfg_q;
	in_word_t item_s1;
	logic     valid_s1;
	logic     move_s1;
	logic     in_take;
	logic     q_free;
	logic     emit;
	bundle_t  bundle;

	assign cfg_ready = 1'b1;
	assign move_s1   = valid_s1 && q_free;
	assign in_stall  = valid_s1 && !q_free;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload    <= MAX_PAYLOAD_RST;
			cfg_q.timestamp_step <= TS_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_PAYLOAD: cfg_q.max_payload    <= cfg_data[10:0];
				CFG_TS_STEP:     cfg_q.timestamp_step <= cfg_data;
				default:         cfg_q                <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !move_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_word;
		end
	end

	h264fu_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (move_s1),
		.item    (item_s1),
		.cfg     (cfg_q),
		.bundle  (bundle),
		.emit    (emit)
	);

	// Words that give no result only update state and never occupy the queue.
	h264fu_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (move_s1 && emit),
		.bundle (bundle),
		.free   (q_free),
		.valid  (out_valid),
		.stall  (out_stall),
		.word   (out_word)
	);

endmodule

FILE: rtl/h264fu_step.sv
// ----------------------------------------------------------------------------
// h264fu_step: packetizer state and per-word decision logic
// Holds the open unit's state and, for the registered input word, builds the
// bundle of output words and the next state in a single pass.
// ----------------------------------------------------------------------------
module h264fu_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  h264fu_pkg::in_word_t item,
	input  h264fu_pkg::cfg_t   cfg,
	output h264fu_pkg::bundle_t bundle,
	output logic               emit
);
	import h264fu_pkg::*;

	state_t      st_q;
	state_t      st_d;
	logic [10:0] m_eff;
	logic [15:0] m16;
	logic [15:0] size_z;
	logic [15:0] size_s;
	logic [15:0] seq_pre;
	logic [15:0] seq_inc;
	logic [31:0] ts_adv;
	logic [15:0] brem_dec;
	logic [10:0] fill_inc;
	logic        closes;
	logic [7:0]  fu_hdr;
	logic [4:0]  new_type;
	logic [4:0]  held_type;

	always_comb begin
		m_eff     = (cfg.max_payload == 11'd0) ? 11'd1 : cfg.max_payload;
		m16       = {5'd0, m_eff};
		size_z    = (item.unit_size == 16'd0) ? 16'd1 : item.unit_size;
		size_s    = (32'(size_z) > MAX_UNIT_BYTES) ? 16'(MAX_UNIT_BYTES) : size_z;
		new_type  = item.nal_byte[4:0];
		held_type = st_q.held[4:0];
		brem_dec  = st_q.brem - 16'd1;
		fill_inc  = st_q.fill + 11'd1;
		closes    = (brem_dec == 16'd0) || (fill_inc >= m_eff);
		ts_adv    = st_q.ts + {15'd0, cfg.timestamp_step};

		// A new unit drops an open one; a begun packet still consumes a number.
		seq_pre = st_q.seq;
		if (item.unit_first && st_q.brem != 16'd0 && (!st_q.fmode || st_q.fill != 11'd0)) begin
			seq_pre = st_q.seq + 16'd1;
		end
		seq_inc = seq_pre + 16'd1;

		fu_hdr = st_q.held & TYPE_MASK;
		if (st_q.first) begin
			fu_hdr = fu_hdr | FU_START;
		end else if (st_q.brem <= m16) begin
			fu_hdr = fu_hdr | FU_END;
		end

		st_d             = st_q;
		bundle.bytes     = '0;
		bundle.pkt_first = '0;
		bundle.pkt_last  = '0;
		bundle.n_res     = 2'd0;
		bundle.seq       = seq_pre;
		bundle.ts        = st_q.ts;

		if (item.unit_first) begin
			st_d.held  = item.nal_byte;
			st_d.fmode = 1'b0;
			st_d.fill  = 11'd0;
			st_d.first = 1'b0;
			st_d.brem  = size_s - 16'd1;
			st_d.seq   = seq_pre;
			if (size_s <= m16) begin
				bundle.bytes[0]     = item.nal_byte;
				bundle.pkt_first[0] = 1'b1;
				bundle.pkt_last[0]  = (size_s == 16'd1);
				bundle.n_res        = 2'd1;
				if (size_s == 16'd1) begin
					st_d.seq = seq_inc;
					if (new_type != SPS_TYPE && new_type != PPS_TYPE) begin
						st_d.ts = ts_adv;
					end
				end
			end else begin
				st_d.fmode = 1'b1;
				st_d.first = 1'b1;
			end
		end else if (st_q.brem == 16'd0) begin
			st_d = st_q;
		end else if (!st_q.fmode) begin
			st_d.brem           = brem_dec;
			bundle.bytes[0]     = item.nal_byte;
			bundle.pkt_last[0]  = (brem_dec == 16'd0);
			bundle.n_res        = 2'd1;
			if (brem_dec == 16'd0) begin
				st_d.seq = seq_inc;
				if (held_type != SPS_TYPE && held_type != PPS_TYPE) begin
					st_d.ts = ts_adv;
				end
			end
		end else begin
			if (st_q.fill == 11'd0) begin
				bundle.bytes[0]     = (st_q.held & NRI_MASK) | {3'd0, FU_A_TYPE};
				bundle.pkt_first[0] = 1'b1;
				bundle.bytes[1]     = fu_hdr;
				bundle.bytes[2]     = item.nal_byte;
				bundle.pkt_last[2]  = closes;
				bundle.n_res        = 2'd3;
			end else begin
				bundle.bytes[0]    = item.nal_byte;
				bundle.pkt_last[0] = closes;
				bundle.n_res       = 2'd1;
			end
			st_d.brem = brem_dec;
			st_d.fill = fill_inc;
			if (closes) begin
				st_d.seq   = seq_inc;
				st_d.fill  = 11'd0;
				st_d.first = 1'b0;
				if (brem_dec == 16'd0) begin
					st_d.ts    = ts_adv;
					st_d.fmode = 1'b0;
				end
			end
		end
	end

	assign emit = (bundle.n_res != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

`ifndef ASSERT_OFF
	a_fill_in_frag: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fill != 11'd0 |-> st_q.fmode)
		else $error("fragment fill is nonzero outside fragment mode");
	a_frag_open: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fmode |-> st_q.brem != 16'd0)
		else $error("fragment mode with no bytes remaining");
	a_first_frag: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.first |-> st_q.fmode)
		else $error("first fragment flag set outside fragment mode");
`endif

endmodule

FILE: rtl/h264fu_outq.sv
// ----------------------------------------------------------------------------
// h264fu_outq: result register and output serializer
// Holds one input word's bundle and hands its output words out one per cycle
// unless stalled; it frees itself on the cycle its last word is taken.
// ----------------------------------------------------------------------------
module h264fu_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  h264fu_pkg::bundle_t bundle,
	output logic                free,
	output logic                valid,
	input  logic                stall,
	output h264fu_pkg::out_word_t word
);
	import h264fu_pkg::*;

	bundle_t    bun_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       at_last;
	logic       take;

	assign at_last = (idx_q == bun_q.n_res - 2'd1);
	assign take    = valid_q && !stall;
	assign free    = !valid_q || (take && at_last);
	assign valid   = valid_q;

	always_comb begin
		word.payload_byte    = bun_q.bytes[idx_q];
		word.packet_first    = bun_q.pkt_first[idx_q];
		word.packet_last     = bun_q.pkt_last[idx_q];
		word.sequence_number = bun_q.seq;
		word.rtp_timestamp   = bun_q.ts;
		word.run_last        = at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (at_last) begin
				valid_q <= 1'b0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bun_q <= bundle;
		end
	end

`ifndef ASSERT_OFF
	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (bun_q.n_res == 2'd1 || bun_q.n_res == 2'd3))
		else $error("held bundle has an illegal word count");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < bun_q.n_res)
		else $error("serializer index ran past the bundle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("bundle loaded over words not yet delivered");
`endif

endmodule
